// ===== design/dbtg_pkg.sv =====
// Package with the constants, register codes and microcode types of the beep tone generator.
package dbtg_pkg;

  localparam int unsigned PHASE_W = 24;
  localparam int unsigned ENV_W = 25;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned MAG_W = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W = ENV_W + GAIN_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned STEP_W = 3;

  localparam int unsigned SINE_ADDRESS_BITS_DEFAULT = 10;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 24'd471859;
  localparam logic [GAIN_W-1:0] DECAY_FACTOR_RESET = 16'd65497;
  localparam logic [GAIN_W-1:0] AMPLITUDE_RESET = 16'd53739;
  localparam logic [ENV_W-1:0] ENVELOPE_FLOOR_RESET = 25'd168;
  localparam logic [ENV_W-1:0] ENV_ONE = 25'h100_0000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_DECAY_FACTOR = 2'd1,
    CFG_AMPLITUDE = 2'd2,
    CFG_ENVELOPE_FLOOR = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_SINE_ENV = 2'd1,
    MUL_AMP = 2'd2,
    MUL_DECAY = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic rom_rd;
    mul_sel_t mul_sel;
    logic out_load;
    logic wait_out;
    logic env_load;
    logic last;
  } ctrl_word_t;

  localparam logic [STEP_W-1:0] STEP_ROM = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SINE_ENV = 3'd1;
  localparam logic [STEP_W-1:0] STEP_AMP = 3'd2;
  localparam logic [STEP_W-1:0] STEP_OUT = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ENV = 3'd4;

  // Quarter-wave sine entry k, Q30 Taylor series through x^15, scaled to 32767.
  function automatic logic [MAG_W-1:0] sine_q15(input int unsigned k, input int unsigned aw);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] s;
    logic [63:0] r;
    x = (64'(2 * k + 1) * HALF_PI_Q30) >> (aw + 1);
    x2 = (x * x) >> 30;
    s = $signed(x);
    t = x;
    t = ((t * x2) >> 30) / 64'd6;
    s = s - $signed(t);
    t = ((t * x2) >> 30) / 64'd20;
    s = s + $signed(t);
    t = ((t * x2) >> 30) / 64'd42;
    s = s - $signed(t);
    t = ((t * x2) >> 30) / 64'd72;
    s = s + $signed(t);
    t = ((t * x2) >> 30) / 64'd110;
    s = s - $signed(t);
    t = ((t * x2) >> 30) / 64'd156;
    s = s + $signed(t);
    t = ((t * x2) >> 30) / 64'd210;
    s = s - $signed(t);
    if (s < 0) begin
      s = 64'sd0;
    end
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end
    r = ($unsigned(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    return r[MAG_W-1:0];
  endfunction

endpackage

// ===== design/decaying_beep_tone_generator.sv =====
// Decaying beep tone generator: microcoded sine oscillator with exponential envelope.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall    alert_level
//   out      output     out_valid / out_stall  sample
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// Each word is accepted and then runs five microcode steps sharing one
// 25x16 multiplier and a registered sine ROM read.
// The output step waits while the previous sample is still held and stalled.
// The next word is taken once the envelope update step has finished.
// Reset is synchronous; it restores register defaults and clears phase and envelope.
module decaying_beep_tone_generator
  import dbtg_pkg::*;
#(
  parameter int unsigned SINE_ADDRESS_BITS = SINE_ADDRESS_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       alert_level,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned RomSize = 1 << SINE_ADDRESS_BITS;
  localparam int unsigned AddrLsb = PHASE_W - 2 - SINE_ADDRESS_BITS;

  typedef logic [RomSize-1:0][MAG_W-1:0] rom_t;

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k < RomSize; k++) begin
      r[k] = sine_q15(k, SINE_ADDRESS_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] s);
    ctrl_word_t c;
    c = '{rom_rd: 1'b0, mul_sel: MUL_NONE, out_load: 1'b0, wait_out: 1'b0,
          env_load: 1'b0, last: 1'b0};
    unique case (s)
      STEP_ROM: c.rom_rd = 1'b1;
      STEP_SINE_ENV: c.mul_sel = MUL_SINE_ENV;
      STEP_AMP: c.mul_sel = MUL_AMP;
      STEP_OUT: begin
        c.out_load = 1'b1;
        c.wait_out = 1'b1;
        c.mul_sel = MUL_DECAY;
      end
      STEP_ENV: begin
        c.env_load = 1'b1;
        c.last = 1'b1;
      end
      default: c.last = 1'b1;
    endcase
    return c;
  endfunction

  logic [PHASE_W-1:0] phase_step;
  logic [GAIN_W-1:0] decay_factor;
  logic [GAIN_W-1:0] amplitude;
  logic [ENV_W-1:0] envelope_floor;

  logic [PHASE_W-1:0] phase;
  logic [ENV_W-1:0] envelope;
  logic previous_alert;
  logic busy;
  logic [STEP_W-1:0] step;

  logic [MAG_W-1:0] mag;
  logic negative;
  logic [PROD_W-1:0] prod;

  ctrl_word_t cw;
  logic hold;
  logic run;
  logic in_accept;
  logic rise;
  logic [SINE_ADDRESS_BITS-1:0] rom_addr;
  logic [ENV_W-1:0] mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [PROD_W-1:0] rnd1;
  logic [PROD_W-1:0] rnd2;
  logic [MAG_W-1:0] m1;
  logic [MAG_W-1:0] m2;
  logic [ENV_W-1:0] env_dec;
  logic [ENV_W-1:0] env_next;
  logic [SAMPLE_W-1:0] sample_next;

  assign cw = ucode(step);
  assign hold = cw.wait_out && out_valid && out_stall;
  assign run = busy && !hold;
  assign in_stall = busy;
  assign in_accept = in_valid && !busy;
  assign rise = alert_level && !previous_alert;

  always_comb begin
    rom_addr = phase[PHASE_W-3:AddrLsb];
    if (phase[PHASE_W-2]) begin
      rom_addr = ~phase[PHASE_W-3:AddrLsb];
    end
  end

  always_comb begin
    rnd1 = prod + (PROD_W'(1) << 23);
    rnd2 = prod + (PROD_W'(1) << 15);
    m1 = rnd1[24 +: MAG_W];
    m2 = rnd2[16 +: MAG_W];
    env_dec = prod[GAIN_W +: ENV_W];
    env_next = (env_dec < envelope_floor) ? '0 : env_dec;
    sample_next = negative ? (SAMPLE_W'(0) - {1'b0, m2}) : {1'b0, m2};
    unique case (cw.mul_sel)
      MUL_SINE_ENV: begin
        mul_a = envelope;
        mul_b = {1'b0, mag};
      end
      MUL_AMP: begin
        mul_a = {{(ENV_W - GAIN_W){1'b0}}, amplitude};
        mul_b = {1'b0, m1};
      end
      MUL_DECAY: begin
        mul_a = envelope;
        mul_b = decay_factor;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RESET;
      decay_factor <= DECAY_FACTOR_RESET;
      amplitude <= AMPLITUDE_RESET;
      envelope_floor <= ENVELOPE_FLOOR_RESET;
      phase <= '0;
      envelope <= '0;
      previous_alert <= 1'b0;
      busy <= 1'b0;
      step <= STEP_ROM;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PHASE_STEP: phase_step <= cfg_data[PHASE_W-1:0];
          CFG_DECAY_FACTOR: decay_factor <= cfg_data[GAIN_W-1:0];
          CFG_AMPLITUDE: amplitude <= cfg_data[GAIN_W-1:0];
          CFG_ENVELOPE_FLOOR: envelope_floor <= cfg_data[ENV_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        previous_alert <= alert_level;
        phase <= (rise ? '0 : phase) + phase_step;
        if (rise) begin
          envelope <= ENV_ONE;
        end
        busy <= 1'b1;
        step <= STEP_ROM;
      end else if (run) begin
        if (cw.env_load) begin
          envelope <= env_next;
        end
        if (cw.last) begin
          busy <= 1'b0;
          step <= STEP_ROM;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      if (run && cw.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run && cw.rom_rd) begin
      mag <= SINE_ROM[rom_addr];
      negative <= phase[PHASE_W-1];
    end
    if (run && cw.mul_sel != MUL_NONE) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (run && cw.out_load) begin
      sample <= sample_next;
    end
  end

`ifndef SYNTHESIS
  a_env_bound: assert property (@(posedge clk) disable iff (rst) envelope <= ENV_ONE)
    else $error("Envelope exceeds 1.0.");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> busy && step == STEP_ROM)
    else $error("Accepted word did not start the program.");
  a_step_range: assert property (@(posedge clk) disable iff (rst) busy |-> step <= STEP_ENV)
    else $error("Step counter ran past the program.");
  a_out_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("Output word appeared without a running program.");
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample != 16'sh8000)
    else $error("Sample reached the negative full-scale code.");
`endif

endmodule
